// ----- rtl/core/iirtdf_pkg.sv -----
// Package for the transposed direct form II IIR filter.
// Holds the fixed widths, the configuration register indexes and the sequencer states.
// It depends on nothing else.
package iirtdf_pkg;

  localparam int Order        = 5;
  localparam int SampleWidth  = 16;
  localparam int CoefWidth    = 32;
  localparam int CoefFracBits = 26;
  localparam int DelayWidth   = 48;
  localparam int ProdWidth    = CoefWidth + SampleWidth;
  localparam int RoundWidth   = DelayWidth + 2;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 64;
  localparam int StepWidth    = $clog2(2 * Order + 2);
  localparam int CoefIdxWidth = $clog2(Order + 1);

  localparam logic [StepWidth-1:0] LastMulStep = StepWidth'(2 * Order);
  localparam logic [StepWidth-1:0] LastStep    = StepWidth'(2 * Order + 1);

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_BYPASS = 3'd0,
    CFG_FF_01  = 3'd1,
    CFG_FF_23  = 3'd2,
    CFG_FF_45  = 3'd3,
    CFG_FB_12  = 3'd4,
    CFG_FB_34  = 3'd5,
    CFG_FB_5   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/core/iir_transposed_df2_filter.sv -----
// Fifth-order IIR filter in transposed direct form II with a single shared multiplier.
// Depends on iirtdf_pkg for widths, register indexes and sequencer states.
//
// An accepted item runs through twelve sequencer steps and then a result stage, which
// hands the result to the output register once that register is free. The
// steps are set by the single 32x16 multiplier, which forms the eleven products
// b0*x, b1*x, a1*y, ..., b5*x, a5*y one per cycle, with each product registered
// and accumulated in the step after it. In bypass an item skips the steps. A new item is
// accepted while an earlier result still waits in the output register.
module iir_transposed_df2_filter
  import iirtdf_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SampleWidth-1:0]  sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SampleWidth-1:0]  sample_out_o,
  output logic                           saturated_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]         cfg_index_i,
  input  logic [CfgDataWidth-1:0]        cfg_data_i
);

  localparam logic signed [DelayWidth-1:0] DelayMax = {1'b0, {(DelayWidth-1){1'b1}}};
  localparam logic signed [DelayWidth-1:0] DelayMin = {1'b1, {(DelayWidth-1){1'b0}}};
  localparam int YFullWidth = RoundWidth - CoefFracBits;
  localparam logic signed [YFullWidth-1:0] YMax =
    YFullWidth'((64'sd1 <<< (SampleWidth - 1)) - 64'sd1);
  localparam logic signed [YFullWidth-1:0] YMin = -YMax - YFullWidth'(1);
  localparam logic signed [RoundWidth-1:0] RoundHalf = RoundWidth'(64'sd1 <<< (CoefFracBits - 1));

  state_e state_q, state_d;

  logic                          bypass_q;
  logic signed [CoefWidth-1:0]   coef_b_q [0:Order];
  logic signed [CoefWidth-1:0]   coef_a_q [1:Order];
  logic signed [DelayWidth-1:0]  delay_q  [0:Order-1];

  logic [StepWidth-1:0]          step_q;
  logic signed [SampleWidth-1:0] x_q, y_q;
  logic                          sat_q;
  logic signed [ProdWidth-1:0]   prod_q;
  logic signed [DelayWidth:0]    acc_q;

  logic                          out_valid_q;
  logic signed [SampleWidth-1:0] sample_out_q;
  logic                          saturated_q;

  logic                          in_acc, out_free, load_out, run_step;
  logic [CoefIdxWidth-1:0]       half_step;
  logic signed [CoefWidth-1:0]   mul_coef;
  logic signed [SampleWidth-1:0] mul_opnd;
  logic signed [ProdWidth-1:0]   mul_res;
  logic signed [RoundWidth-1:0]  round_sum;
  logic signed [YFullWidth-1:0]  y_full;
  logic signed [SampleWidth-1:0] y_clip;
  logic                          y_sat;
  logic signed [DelayWidth-1:0]  acc_start;
  logic signed [RoundWidth-1:0]  delay_sum;
  logic signed [DelayWidth-1:0]  delay_new;

  function automatic logic signed [DelayWidth-1:0] clip_delay(
    input logic signed [RoundWidth-1:0] v
  );
    logic signed [DelayWidth-1:0] r;
    if (v > RoundWidth'(DelayMax)) begin
      r = DelayMax;
    end else if (v < RoundWidth'(DelayMin)) begin
      r = DelayMin;
    end else begin
      r = v[DelayWidth-1:0];
    end
    return r;
  endfunction

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign saturated_o  = saturated_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign half_step = CoefIdxWidth'(step_q >> 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = bypass_q ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == LastStep) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    run_step   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RUN:  run_step   = 1'b1;
      ST_DONE: load_out   = out_free;
      default: ;
    endcase
  end

  // Operand selection for the shared multiplier: even steps take a feedback
  // coefficient with y, odd steps and the first step a feedforward one with x.
  always_comb begin
    mul_coef = '0;
    mul_opnd = x_q;
    if (step_q == '0) begin
      mul_coef = coef_b_q[0];
    end else if (step_q <= LastMulStep) begin
      if (step_q[0]) begin
        mul_coef = coef_b_q[CoefIdxWidth'((step_q + StepWidth'(1)) >> 1)];
      end else begin
        mul_coef = coef_a_q[half_step];
        mul_opnd = y_q;
      end
    end
  end

  assign mul_res = mul_coef * mul_opnd;

  assign round_sum = RoundWidth'(prod_q) + RoundWidth'(delay_q[0]) + RoundHalf;
  assign y_full    = round_sum[RoundWidth-1:CoefFracBits];

  always_comb begin
    y_sat  = 1'b0;
    y_clip = y_full[SampleWidth-1:0];
    if (y_full > YMax) begin
      y_clip = YMax[SampleWidth-1:0];
      y_sat  = 1'b1;
    end else if (y_full < YMin) begin
      y_clip = YMin[SampleWidth-1:0];
      y_sat  = 1'b1;
    end
  end

  always_comb begin
    acc_start = '0;
    if (half_step < CoefIdxWidth'(Order)) begin
      acc_start = delay_q[half_step];
    end
  end

  assign delay_sum = RoundWidth'(acc_q) - RoundWidth'(prod_q);
  assign delay_new = clip_delay(delay_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        step_q <= '0;
      end else if (run_step) begin
        step_q <= step_q + StepWidth'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
      for (int i = 0; i <= Order; i++) begin
        coef_b_q[i] <= '0;
      end
      for (int i = 1; i <= Order; i++) begin
        coef_a_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BYPASS: bypass_q <= cfg_data_i[0];
        CFG_FF_01: begin
          coef_b_q[0] <= cfg_data_i[31:0];
          coef_b_q[1] <= cfg_data_i[63:32];
        end
        CFG_FF_23: begin
          coef_b_q[2] <= cfg_data_i[31:0];
          coef_b_q[3] <= cfg_data_i[63:32];
        end
        CFG_FF_45: begin
          coef_b_q[4] <= cfg_data_i[31:0];
          coef_b_q[5] <= cfg_data_i[63:32];
        end
        CFG_FB_12: begin
          coef_a_q[1] <= cfg_data_i[31:0];
          coef_a_q[2] <= cfg_data_i[63:32];
        end
        CFG_FB_34: begin
          coef_a_q[3] <= cfg_data_i[31:0];
          coef_a_q[4] <= cfg_data_i[63:32];
        end
        CFG_FB_5: coef_a_q[5] <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Order; i++) begin
        delay_q[i] <= '0;
      end
    end else if (run_step && step_q >= StepWidth'(3) && step_q[0]) begin
      delay_q[half_step - CoefIdxWidth'(1)] <= delay_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= sample_in_i;
      y_q   <= sample_in_i;
      sat_q <= 1'b0;
    end else if (run_step) begin
      prod_q <= mul_res;
      if (step_q == StepWidth'(1)) begin
        y_q   <= y_clip;
        sat_q <= y_sat;
      end else if (step_q >= StepWidth'(2) && !step_q[0]) begin
        acc_q <= (DelayWidth+1)'(acc_start) + (DelayWidth+1)'(prod_q);
      end
    end
    if (load_out) begin
      sample_out_q <= y_q;
      saturated_q  <= sat_q;
    end
  end

  a_bypass_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && bypass_q |=> state_q == ST_DONE)
    else $error("bypass item did not go straight to the result stage");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && step_q == LastStep |=> state_q == ST_DONE)
    else $error("sequencer did not finish after its last step");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_valid_o && state_q == ST_IDLE)
    else $error("result was not handed to the output register");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      sample_out_o == YMax[SampleWidth-1:0] || sample_out_o == YMin[SampleWidth-1:0])
    else $error("saturation flag set on an unclipped sample");

endmodule

// ----- bench/iir_transposed_df2_filter_test.sv -----
// Self-checking testbench for the transposed direct form II IIR filter.
// Depends on iirtdf_pkg and the iir_transposed_df2_filter RTL; a scoreboard class holds
// its own fixed-point copy of the filter and checks every output item in order.
module iir_transposed_df2_filter_test;
  import iirtdf_pkg::*;

  localparam longint SampleMax     = (longint'(1) <<< (SampleWidth - 1)) - 1;
  localparam longint SampleMin     = -SampleMax - 1;
  localparam longint DelayMax      = (longint'(1) <<< (DelayWidth - 1)) - 1;
  localparam longint DelayMin      = -DelayMax - 1;
  localparam int     RandomItems   = 1700;
  localparam int     CalmItems     = 150;
  localparam int     HoldAfter     = 400;
  localparam int     LongHold      = 300;
  localparam int     WatchdogLimit = 3000;
  localparam int     DrainCycles   = 30;
  localparam int     ReportLimit   = 100;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          sat;
  } filtered_t;

  typedef enum int {
    KIND_BYPASS,
    KIND_ANY,
    KIND_STABLE,
    KIND_REDUCED,
    KIND_EXTREME
  } phase_kind_e;

  class iir_response_board;
    bit                           bypass_en;
    logic signed [CoefWidth-1:0]  ff_coef [Order+1];
    logic signed [CoefWidth-1:0]  fb_coef [Order+1];
    logic signed [DelayWidth-1:0] delay_val [Order];
    filtered_t                    expected_q [$];
    int                           errors;

    function new();
      bypass_en = 1'b1;
      foreach (ff_coef[i]) begin
        ff_coef[i] = '0;
        fb_coef[i] = '0;
      end
      foreach (delay_val[i]) delay_val[i] = '0;
      errors = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_BYPASS: bypass_en = data[0];
        CFG_FF_01: begin
          ff_coef[0] = data[CoefWidth-1:0];
          ff_coef[1] = data[CfgDataWidth-1:CoefWidth];
        end
        CFG_FF_23: begin
          ff_coef[2] = data[CoefWidth-1:0];
          ff_coef[3] = data[CfgDataWidth-1:CoefWidth];
        end
        CFG_FF_45: begin
          ff_coef[4] = data[CoefWidth-1:0];
          ff_coef[5] = data[CfgDataWidth-1:CoefWidth];
        end
        CFG_FB_12: begin
          fb_coef[1] = data[CoefWidth-1:0];
          fb_coef[2] = data[CfgDataWidth-1:CoefWidth];
        end
        CFG_FB_34: begin
          fb_coef[3] = data[CoefWidth-1:0];
          fb_coef[4] = data[CfgDataWidth-1:CoefWidth];
        end
        CFG_FB_5: fb_coef[5] = data[CoefWidth-1:0];
        default: ;
      endcase
    endfunction

    // The feedback terms use the rounded and clipped output, as the hardware does.
    function void take_sample(logic signed [SampleWidth-1:0] x);
      longint    xv;
      longint    acc;
      longint    yv;
      longint    sum;
      int        i;
      filtered_t res;
      xv = x;
      res.sat = 1'b0;
      if (bypass_en) begin
        res.sample = x;
      end else begin
        acc = longint'(ff_coef[0]) * xv + longint'(delay_val[0]);
        yv = (acc + (longint'(1) <<< (CoefFracBits - 1))) >>> CoefFracBits;
        if (yv > SampleMax) begin
          yv = SampleMax;
          res.sat = 1'b1;
        end else if (yv < SampleMin) begin
          yv = SampleMin;
          res.sat = 1'b1;
        end
        res.sample = SampleWidth'(yv);
        for (i = 0; i < Order; i++) begin
          if (i < Order - 1) begin
            sum = longint'(delay_val[i+1]);
          end else begin
            sum = 0;
          end
          sum = sum + longint'(ff_coef[i+1]) * xv - longint'(fb_coef[i+1]) * yv;
          if (sum > DelayMax) begin
            sum = DelayMax;
          end else if (sum < DelayMin) begin
            sum = DelayMin;
          end
          delay_val[i] = DelayWidth'(sum);
        end
      end
      expected_q = {expected_q, res};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void check_filtered(logic signed [SampleWidth-1:0] s, logic sat);
      filtered_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) begin
          $error("unexpected output item: sample_out %0d, saturated %0b", s, sat);
        end
        return;
      end
      want = expected_q.pop_front();
      if (s !== want.sample) begin
        errors++;
        if (errors <= ReportLimit) begin
          $error("sample_out: expected %0d, actual %0d", want.sample, s);
        end
      end
      if (sat !== want.sat) begin
        errors++;
        if (errors <= ReportLimit) begin
          $error("saturated: expected %0b, actual %0b", want.sat, sat);
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [SampleWidth-1:0] sample_in_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SampleWidth-1:0] sample_out_o;
  logic                          saturated_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CfgIdxWidth-1:0]        cfg_index_i = '0;
  logic [CfgDataWidth-1:0]       cfg_data_i = '0;

  iir_response_board board;
  logic [CoefWidth-1:0] coef_b [Order+1];
  logic [CoefWidth-1:0] coef_a [Order+1];
  bit                   bypass_sel;
  int                   tx_idle_pct = 0;
  int                   rx_idle_pct = 0;
  int                   filtered_count = 0;
  int                   random_sent = 0;

  iir_transposed_df2_filter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .saturated_o  (saturated_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_sample(input logic signed [SampleWidth-1:0] x);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_sample(x);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_register(idx, data);
  endtask

  // Bits that the block ignores carry random values.
  task automatic program_filter();
    logic [CfgDataWidth-1:0] flag;
    flag    = {$urandom(), $urandom()};
    flag[0] = bypass_sel;
    write_reg(CFG_BYPASS, flag);
    write_reg(CFG_FF_01, {coef_b[1], coef_b[0]});
    write_reg(CFG_FF_23, {coef_b[3], coef_b[2]});
    write_reg(CFG_FF_45, {coef_b[5], coef_b[4]});
    write_reg(CFG_FB_12, {coef_a[2], coef_a[1]});
    write_reg(CFG_FB_34, {coef_a[4], coef_a[3]});
    write_reg(CFG_FB_5, {CoefWidth'($urandom()), coef_a[5]});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic clear_coefs();
    foreach (coef_b[i]) begin
      coef_b[i] = '0;
      coef_a[i] = '0;
    end
  endtask

  function automatic logic [CoefWidth-1:0] extreme_coef();
    case ($urandom_range(0, 4))
      0: return {1'b0, {(CoefWidth-1){1'b1}}};
      1: return {1'b1, {(CoefWidth-1){1'b0}}};
      2: return '0;
      3: return CoefWidth'(1 << CoefFracBits);
      default: return CoefWidth'(-(1 << CoefFracBits));
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [SampleWidth-1:0] random_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return SampleWidth'($urandom());
    if (pick < 85) return SampleWidth'(int'($urandom_range(0, 512)) - 256);
    case ($urandom_range(0, 3))
      0: return {1'b1, {(SampleWidth-1){1'b0}}};
      1: return {1'b0, {(SampleWidth-1){1'b1}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic run_phase(input int n_items, input bit calm);
    phase_kind_e kind;
    int          top;
    int          k;
    kind       = phase_kind_e'($urandom_range(0, 4));
    bypass_sel = (kind == KIND_BYPASS);
    for (k = 0; k <= Order; k++) begin
      case (kind)
        KIND_STABLE, KIND_REDUCED: begin
          coef_b[k] = CoefWidth'(int'($urandom_range(0, 1 << (CoefFracBits + 1)))
                                 - (1 << CoefFracBits));
          coef_a[k] = CoefWidth'(int'($urandom_range(0, 1 << (CoefFracBits - 2)))
                                 - (1 << (CoefFracBits - 3)));
        end
        KIND_EXTREME: begin
          coef_b[k] = extreme_coef();
          coef_a[k] = extreme_coef();
        end
        default: begin
          coef_b[k] = $urandom();
          coef_a[k] = $urandom();
        end
      endcase
    end
    if (kind == KIND_REDUCED) begin
      top = $urandom_range(1, Order - 1);
      for (k = top + 1; k <= Order; k++) begin
        coef_b[k] = '0;
        coef_a[k] = '0;
      end
    end
    tx_idle_pct = calm ? 0 : pick_idle_pct();
    rx_idle_pct = calm ? 0 : pick_idle_pct();
    program_filter();
    repeat (n_items) send_sample(random_sample());
    drain();
    random_sent += n_items;
  endtask

  initial begin : output_side
    int  stall_left;
    bit  long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        board.check_filtered(sample_out_o, saturated_o);
        filtered_count++;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!long_hold_done && filtered_count >= HoldAfter) begin
        long_hold_done = 1'b1;
        stall_left     = LongHold - 1;
        out_ready_i    <= 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        stall_left  = $urandom_range(1, 7) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    board = new();
    clear_coefs();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The filter comes out of reset in bypass.
    send_sample(SampleWidth'(-32768));
    send_sample(SampleWidth'(32767));
    send_sample(SampleWidth'(0));
    send_sample(SampleWidth'(-1));
    drain();

    // A gain of one half puts the output exactly on rounding ties.
    bypass_sel = 1'b0;
    coef_b[0]  = CoefWidth'(1 << (CoefFracBits - 1));
    program_filter();
    send_sample(SampleWidth'(1));
    send_sample(SampleWidth'(-1));
    send_sample(SampleWidth'(3));
    send_sample(SampleWidth'(-3));
    send_sample(SampleWidth'(32767));
    drain();

    // Full-scale coefficients drive both the output and the delays into clipping.
    foreach (coef_b[i]) begin
      coef_b[i] = {1'b1, {(CoefWidth-1){1'b0}}};
      coef_a[i] = {1'b0, {(CoefWidth-1){1'b1}}};
    end
    coef_b[0] = {1'b0, {(CoefWidth-1){1'b1}}};
    program_filter();
    send_sample(SampleWidth'(32767));
    send_sample(SampleWidth'(32767));
    send_sample(SampleWidth'(-32768));
    send_sample(SampleWidth'(-32768));
    send_sample(SampleWidth'(1000));
    send_sample(SampleWidth'(0));
    drain();

    // Bypass must leave the delay line alone for when filtering resumes.
    bypass_sel = 1'b1;
    program_filter();
    send_sample(SampleWidth'(12345));
    send_sample(SampleWidth'(-12345));
    drain();
    bypass_sel = 1'b0;
    program_filter();
    send_sample(SampleWidth'(0));
    send_sample(SampleWidth'(0));
    drain();

    while (random_sent < RandomItems - CalmItems) begin
      run_phase($urandom_range(60, 140), 1'b0);
    end
    run_phase(CalmItems, 1'b1);

    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
